// ===== hw/rtl/particle_table_euler_integrator_unit_defines.svh =====
// Assertion macros shared by the particle table RTL.
// Plain text macros; no dependencies.
`ifndef PARTICLE_TABLE_EULER_INTEGRATOR_UNIT_DEFINES_SVH
`define PARTICLE_TABLE_EULER_INTEGRATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PTE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pte assertion failed");

// Next-cycle implication, disabled while reset is high.
`define PTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pte assertion failed");

`endif

// ===== hw/rtl/pte_pkg.sv =====
// Types, constants and saturation/boundary helpers of the particle table.
// No dependencies; used by pte_div and particle_table_euler_integrator_unit.
package pte_pkg;

   localparam int NUM_PARTICLES_DEF = 32;
   localparam int DIV_STEPS = 40;

   localparam logic [15:0] DRAG_RESET = 16'd64225;

   localparam logic [2:0] CMD_CLEAR = 3'd0;
   localparam logic [2:0] CMD_ADD   = 3'd1;
   localparam logic [2:0] CMD_FORCE = 3'd2;
   localparam logic [2:0] CMD_TICK  = 3'd3;
   localparam logic [2:0] CMD_READ  = 3'd4;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_FULL     = 2'd1;
   localparam logic [1:0] STAT_INACTIVE = 2'd2;

   localparam logic [1:0] BND_WRAP   = 2'd0;
   localparam logic [1:0] BND_BOUNCE = 2'd1;
   localparam logic [1:0] BND_CLAMP  = 2'd2;

   localparam logic signed [23:0] S24_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] S24_MIN = 24'sh800000;
   localparam logic signed [23:0] ONE_Q16 = 24'sd65536;
   localparam logic signed [23:0] TWO_Q16 = 24'sd131072;

   typedef struct packed {
      logic [2:0]         command;
      logic [4:0]         slot;
      logic signed [23:0] position;
      logic signed [23:0] velocity;
      logic [23:0]        mass;
      logic [23:0]        color;
      logic [1:0]         boundary_mode;
      logic signed [23:0] force_req;
      logic [15:0]        delta_time;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [4:0]         result_slot;
      logic               is_active;
      logic signed [23:0] out_position;
      logic signed [23:0] out_velocity;
      logic signed [23:0] out_acceleration;
      logic [23:0]        out_color;
      logic [1:0]         out_boundary;
      logic [5:0]         active_count;
   } rsp_type;

   // One particle record as held in the table memory.
   typedef struct packed {
      logic signed [23:0] pos;
      logic signed [23:0] vel;
      logic signed [23:0] acc;
      logic [23:0]        mass;
      logic [23:0]        color;
      logic [1:0]         bnd;
   } rec_type;

   typedef struct packed {
      logic        start;
      logic [39:0] dividend;
      logic [23:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [39:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic signed [23:0] pos;
      logic signed [23:0] vel;
      logic               kill;
   } bnd_res_type;

   function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
      logic signed [23:0] r;
      if (v > 26'sd8388607) begin
         r = S24_MAX;
      end else if (v < -26'sd8388608) begin
         r = S24_MIN;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

   function automatic logic signed [23:0] neg_sat24(input logic signed [23:0] v);
      logic signed [23:0] r;
      if (v == S24_MIN) begin
         r = S24_MAX;
      end else begin
         r = -v;
      end
      return r;
   endfunction

   // Boundary rule on the unit interval [0, ONE].
   function automatic bnd_res_type bnd_apply(input logic signed [23:0] p,
                                             input logic signed [23:0] v,
                                             input logic [1:0] mode);
      bnd_res_type r;
      logic        hi;
      logic        lo;
      logic [23:0] neg_p;
      hi = p > ONE_Q16;
      lo = p < 24'sd0;
      neg_p = 24'(24'd0 - p);
      r.pos = p;
      r.vel = v;
      r.kill = 1'b0;
      case (mode)
         BND_WRAP: begin
            if (hi) begin
               r.pos = $signed({8'd0, p[15:0]});
            end else if (lo) begin
               r.pos = ONE_Q16 - $signed({8'd0, neg_p[15:0]});
            end
         end
         BND_BOUNCE: begin
            if (hi) begin
               r.pos = TWO_Q16 - p;
               r.vel = neg_sat24(v);
            end else if (lo) begin
               r.pos = neg_sat24(p);
               r.vel = neg_sat24(v);
            end
         end
         BND_CLAMP: begin
            if (hi) begin
               r.pos = ONE_Q16;
               r.vel = '0;
            end else if (lo) begin
               r.pos = '0;
               r.vel = '0;
            end
         end
         default: begin
            r.kill = hi | lo;
         end
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/pte_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle; done rises after the last bit.
// Depends on pte_pkg for the request and result structs.
module pte_div
   import pte_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [23:0] rem_ff, rem_in;
   logic [39:0] quo_ff, quo_in;
   logic [23:0] dsr_ff, dsr_in;

   logic [24:0] shifted;
   logic [25:0] diff;
   logic        ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[39]};
      diff = {1'b0, shifted} - {2'b00, dsr_ff};
      ge = ~diff[25];
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dsr_in = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = div_req.dividend;
         dsr_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[23:0] : shifted[23:0];
         quo_in = {quo_ff[38:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== hw/rtl/particle_table_euler_integrator_unit.sv =====
// Top level of the particle table with Euler integration and boundary rules.
// Depends on pte_pkg, pte_div and particle_table_euler_integrator_unit_defines.svh.
//
//   Channel   Ports                         Direction  Moves
//   request   req_valid/req_stall/req_data  in         one command per transfer
//   response  rsp_valid/rsp_stall/rsp_data  out        one result per command
//   config    csr_we/csr_wdata              in         drag factor, Q0.16
//
// From acceptance to the result entering the output register: clear and unknown
// commands need no table access; read and force fetch the slot, and force waits on
// the divider unless the slot is inactive or the force or mass is zero; add examines
// one slot per cycle until it finds a free one or all are full; tick streams every
// slot through the single read and write port of the table memory and the six-stage
// pipeline behind it. Reset is synchronous and active high; it clears the active
// flags, the live count and the control state and sets the drag factor to DRAG_RESET.
// Result stalls hold the finished result in the output register; a new command is
// taken while it waits, and the next result waits in turn.
`include "particle_table_euler_integrator_unit_defines.svh"

module particle_table_euler_integrator_unit
   import pte_pkg::*;
#(
   parameter int NUM_PARTICLES = NUM_PARTICLES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   localparam int IDX_W = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;
   localparam int CNT_W = $clog2(NUM_PARTICLES + 1);

   // One entry of the tick pipeline: the record travels with its index so the
   // last stage can write the whole record back.
   typedef struct packed {
      logic [IDX_W-1:0]   idx;
      logic               act;
      rec_type            rec;
      logic signed [40:0] wide;
   } tick_stage_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_FORCE,
      ST_DIV,
      ST_FWB,
      ST_TICK,
      ST_READ,
      ST_DONE
   } state_type;

   state_type              state_ff, state_in;
   req_type                req_ff, req_in;
   rsp_type                res_ff, res_in;
   rsp_type                rsp_data_ff, rsp_data_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [NUM_PARTICLES-1:0] active_ff, active_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       scan_ff, scan_in;
   logic [CNT_W-1:0]       iss_ff, iss_in;
   logic signed [23:0]     q_ff, q_in;
   logic [15:0]            drag_ff;

   // Table memory: one record per particle, one write and one read per cycle.
   rec_type                mem [NUM_PARTICLES];
   rec_type                rd_ff;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   rec_type                mem_wdata;
   logic [IDX_W-1:0]       mem_raddr;

   logic                   s0_vld_ff, s0_vld_in;
   logic [IDX_W-1:0]       s0_idx_ff, s0_idx_in;
   logic                   s0_act_ff, s0_act_in;
   logic [5:1]             vld_ff, vld_in;
   tick_stage_type         st1_ff, st1_in;
   tick_stage_type         st2_ff, st2_in;
   tick_stage_type         st3_ff, st3_in;
   tick_stage_type         st4_ff, st4_in;
   tick_stage_type         st5_ff, st5_in;

   div_req_type            div_req;
   div_rsp_type            div_rsp;

   logic [IDX_W-1:0]       slot_idx;
   logic                   slot_ok;
   logic                   rsp_take;
   logic                   pipe_empty;
   logic signed [16:0]     dt_s;
   logic signed [16:0]     drag_s;
   logic [23:0]            force_mag;
   logic signed [23:0]     wb_pos;
   bnd_res_type            wb_bnd;

   pte_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign slot_idx = IDX_W'(req_ff.slot);
   assign slot_ok = (32'(req_ff.slot) < NUM_PARTICLES) && active_ff[slot_idx];
   assign rsp_take = ~rsp_valid_ff | ~rsp_stall;
   assign pipe_empty = ~s0_vld_ff && (vld_ff == '0);
   assign dt_s = $signed({1'b0, req_ff.delta_time});
   assign drag_s = $signed({1'b0, drag_ff});
   assign force_mag = req_ff.force_req[23] ? 24'(24'd0 - req_ff.force_req)
                                           : req_ff.force_req;

   // Tick pipeline. Stage 1 multiplies acceleration by dt, stage 2 adds it to the
   // velocity, stages 3 and 4 apply drag, stage 5 multiplies velocity by dt, and the
   // write-back stage moves the position and applies the boundary rule.
   always_comb begin
      st1_in = '0;
      st1_in.idx = s0_idx_ff;
      st1_in.act = s0_act_ff;
      st1_in.rec = rd_ff;
      st1_in.wide = rd_ff.acc * dt_s;

      st2_in = st1_ff;
      st2_in.rec.vel = sat24(26'(st1_ff.rec.vel) + 26'($signed(st1_ff.wide[40:16])));

      st3_in = st2_ff;
      st3_in.wide = st2_ff.rec.vel * drag_s;

      st4_in = st3_ff;
      st4_in.rec.vel = sat24(26'($signed(st3_ff.wide[40:16])));

      st5_in = st4_ff;
      st5_in.wide = st4_ff.rec.vel * dt_s;

      wb_pos = sat24(26'(st5_ff.rec.pos) + 26'($signed(st5_ff.wide[40:16])));
      wb_bnd = bnd_apply(wb_pos, st5_ff.rec.vel, st5_ff.rec.bnd);

      vld_in = {vld_ff[4:1], s0_vld_ff};
   end

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      res_in = res_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      active_in = active_ff;
      count_in = count_ff;
      scan_in = scan_ff;
      iss_in = iss_ff;
      q_in = q_ff;
      mem_we = 1'b0;
      mem_waddr = slot_idx;
      mem_wdata = rd_ff;
      div_req.start = 1'b0;
      div_req.dividend = {force_mag, 16'd0};
      div_req.divisor = rd_ff.mass;
      s0_vld_in = 1'b0;
      s0_idx_in = iss_ff[IDX_W-1:0];
      s0_act_in = active_ff[iss_ff[IDX_W-1:0]];

      if (state_ff == ST_TICK) begin
         mem_raddr = iss_ff[IDX_W-1:0];
      end else if (state_ff == ST_IDLE) begin
         mem_raddr = IDX_W'(req_data.slot);
      end else begin
         mem_raddr = slot_idx;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               res_in = '0;
               scan_in = '0;
               iss_in = '0;
               case (req_data.command)
                  CMD_CLEAR: begin
                     active_in = '0;
                     count_in = '0;
                     state_in = ST_DONE;
                  end
                  CMD_ADD:   state_in = ST_ADD;
                  CMD_FORCE: state_in = ST_FORCE;
                  CMD_TICK:  state_in = ST_TICK;
                  CMD_READ:  state_in = ST_READ;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_ADD: begin
            if (scan_ff == CNT_W'(NUM_PARTICLES)) begin
               res_in.status = STAT_FULL;
               state_in = ST_DONE;
            end else if (!active_ff[scan_ff[IDX_W-1:0]]) begin
               mem_we = 1'b1;
               mem_waddr = scan_ff[IDX_W-1:0];
               mem_wdata.pos = req_ff.position;
               mem_wdata.vel = req_ff.velocity;
               mem_wdata.acc = '0;
               mem_wdata.mass = req_ff.mass;
               mem_wdata.color = req_ff.color;
               mem_wdata.bnd = req_ff.boundary_mode;
               active_in[scan_ff[IDX_W-1:0]] = 1'b1;
               count_in = count_ff + CNT_W'(1);
               res_in.result_slot = 5'(scan_ff);
               state_in = ST_DONE;
            end else begin
               scan_in = scan_ff + CNT_W'(1);
            end
         end
         ST_FORCE: begin
            res_in.result_slot = req_ff.slot;
            if (!slot_ok) begin
               res_in.status = STAT_INACTIVE;
               state_in = ST_DONE;
            end else if (req_ff.force_req == '0) begin
               q_in = '0;
               state_in = ST_FWB;
            end else if (rd_ff.mass == '0) begin
               q_in = req_ff.force_req[23] ? S24_MIN : S24_MAX;
               state_in = ST_FWB;
            end else begin
               div_req.start = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               if (req_ff.force_req[23]) begin
                  if (div_rsp.quotient > 40'd8388608) begin
                     q_in = S24_MIN;
                  end else begin
                     q_in = 24'(24'd0 - div_rsp.quotient[23:0]);
                  end
               end else begin
                  if (div_rsp.quotient > 40'd8388607) begin
                     q_in = S24_MAX;
                  end else begin
                     q_in = $signed(div_rsp.quotient[23:0]);
                  end
               end
               state_in = ST_FWB;
            end
         end
         ST_FWB: begin
            mem_we = 1'b1;
            mem_wdata.acc = sat24(26'(rd_ff.acc) + 26'(q_ff));
            state_in = ST_DONE;
         end
         ST_TICK: begin
            if (iss_ff != CNT_W'(NUM_PARTICLES)) begin
               s0_vld_in = 1'b1;
               iss_in = iss_ff + CNT_W'(1);
            end else if (pipe_empty) begin
               state_in = ST_DONE;
            end
            if (vld_ff[5] && st5_ff.act) begin
               mem_we = 1'b1;
               mem_waddr = st5_ff.idx;
               mem_wdata = st5_ff.rec;
               mem_wdata.pos = wb_bnd.pos;
               mem_wdata.vel = wb_bnd.vel;
               mem_wdata.acc = '0;
               if (wb_bnd.kill) begin
                  active_in[st5_ff.idx] = 1'b0;
                  if (count_ff != '0) begin
                     count_in = count_ff - CNT_W'(1);
                  end
               end
            end
         end
         ST_READ: begin
            res_in.result_slot = req_ff.slot;
            if (slot_ok) begin
               res_in.is_active = 1'b1;
               res_in.out_position = rd_ff.pos;
               res_in.out_velocity = rd_ff.vel;
               res_in.out_acceleration = rd_ff.acc;
               res_in.out_color = rd_ff.color;
               res_in.out_boundary = rd_ff.bnd;
            end else begin
               res_in.status = STAT_INACTIVE;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_take) begin
               rsp_data_in = res_ff;
               rsp_data_in.active_count = 6'(count_ff);
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         active_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff <= active_in;
         count_ff <= count_in;
      end
      req_ff <= req_in;
      res_ff <= res_in;
      rsp_data_ff <= rsp_data_in;
      scan_ff <= scan_in;
      iss_ff <= iss_in;
      q_ff <= q_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drag_ff <= DRAG_RESET;
      end else if (csr_we) begin
         drag_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
         vld_ff <= '0;
      end else begin
         s0_vld_ff <= s0_vld_in;
         vld_ff <= vld_in;
      end
      s0_idx_ff <= s0_idx_in;
      s0_act_ff <= s0_act_in;
      st1_ff <= st1_in;
      st2_ff <= st2_in;
      st3_ff <= st3_in;
      st4_ff <= st4_in;
      st5_ff <= st5_in;
   end

   // Each entry is written at most once per command, and no read taken in the cycle of a write to its entry is used.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[mem_raddr];
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // The live count always matches the number of active flags.
   `PTE_ASSERT_IMPLY(a_count_matches, clock, reset, 1'b1,
                     32'(count_ff) == $countones(active_ff))
   // The table is never written while waiting for a command.
   `PTE_ASSERT_IMPLY(a_no_idle_write, clock, reset, state_ff == ST_IDLE, !mem_we)
   // A divider result only appears while the force command waits for it.
   `PTE_ASSERT_IMPLY(a_div_done_owned, clock, reset, div_rsp.done, state_ff == ST_DIV)
   // Starting a divide leaves the force state at the next edge.
   `PTE_ASSERT_NEXT(a_div_start_waits, clock, reset, div_req.start, state_ff == ST_DIV)

endmodule
